[sv/rrcb_pkg.sv]
// ----------------------------------------------------------------------------
// rrcb_pkg
// Shared constants, types and arithmetic helpers for the rounded rectangle
// coverage blend core.
// ----------------------------------------------------------------------------
package rrcb_pkg;

  localparam int COORD_BITS = 12;
  localparam int RFRAC      = 4;

  localparam int GEO_W  = 18;
  localparam int RAD_W  = 16;
  localparam int MAXR_W = 13 + RFRAC - 1;
  localparam int RCMP_W = 24;
  localparam int DX_W   = GEO_W + RFRAC + 1;
  localparam int DP_W   = RAD_W + 1;
  localparam int COV_W  = 9;

  localparam int SQ_BITS = DP_W + 1;
  localparam int SQ_ITER = 2;
  localparam int SQ_STG  = SQ_BITS / SQ_ITER;

  localparam int ST_GEO = 0;
  localparam int ST_DXY = 1;
  localparam int ST_SQR = 2;
  localparam int ST_SUM = 3;
  localparam int ST_RT0 = 4;
  localparam int ST_COV = ST_RT0 + SQ_STG;
  localparam int ST_MUL = ST_COV + 1;
  localparam int ST_OUT = ST_COV + 2;
  localparam int NUM_ST = ST_COV + 3;

  localparam logic [RAD_W:0]            HALF     = (RAD_W + 1)'(2 ** (RFRAC - 1));
  localparam logic signed [DX_W-1:0]    HALF_D   = DX_W'(2 ** (RFRAC - 1));
  localparam logic signed [DX_W-1:0]    DX_ZERO  = DX_W'(0);
  localparam logic signed [GEO_W-1:0]   G_ONE    = GEO_W'(1);
  localparam logic [COV_W-1:0]          COV_FULL = COV_W'(256);
  localparam logic [12:0]               BUF_RST  = 13'd4096;

  typedef enum logic [2:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_BUFFER_WIDTH  = 3'd6,
    REG_BUFFER_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic lx;
    logic rx;
    logic ty;
    logic by;
  } zone_t;

  typedef struct packed {
    logic        skip;
    logic        dpos;
    logic [31:0] dst;
  } carry_t;

  typedef struct packed {
    logic [SQ_BITS+1:0]   rem;
    logic [SQ_BITS-1:0]   root;
    logic [2*SQ_BITS-1:0] rad;
  } sq_t;

  // One restoring square root step: brings in two radicand bits, yields one root bit.
  function automatic sq_t sqrt_step(sq_t s);
    logic [SQ_BITS+3:0] rem2;
    logic [SQ_BITS+3:0] trial;
    sq_t                n;
    rem2  = {s.rem, s.rad[2*SQ_BITS-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = s.rad << 2;
    if (rem2 >= trial) begin
      n.rem  = (SQ_BITS + 2)'(rem2 - trial);
      n.root = {s.root[SQ_BITS-2:0], 1'b1};
    end else begin
      n.rem  = (SQ_BITS + 2)'(rem2);
      n.root = {s.root[SQ_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

  // Truncating division by 255, exact for every product of two bytes.
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x >> 8) + 17'd1;
    return t[15:8];
  endfunction

endpackage

[sv/rrcb_if.sv]
// ----------------------------------------------------------------------------
// rrcb_if
// Ready/valid channels for pixel requests into the core and blended pixels
// out of it.
// ----------------------------------------------------------------------------
interface rrcb_pix_in_if import rrcb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [31:0]           dest_pixel;

  modport source(output valid, pixel_x, pixel_y, dest_pixel, input ready);
  modport sink(input valid, pixel_x, pixel_y, dest_pixel, output ready);
endinterface

interface rrcb_pix_out_if import rrcb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] new_pixel;

  modport source(output valid, write_enable, new_pixel, input ready);
  modport sink(input valid, write_enable, new_pixel, output ready);
endinterface

[sv/rounded_rect_coverage_blend_core.sv]
// ----------------------------------------------------------------------------
// rounded_rect_coverage_blend_core
// Antialiased rounded rectangle fill with source-over blending, one pixel
// request per clock through a sixteen stage pipeline unless pix_out back-pressure fills it.
//
//   channel   role    handshake      payload
//   pix_in    sink    valid/ready    pixel_x, pixel_y, dest_pixel
//   pix_out   source  valid/ready    write_enable, new_pixel
//   cfg       sink    cfg_write      cfg_index, cfg_data
//
// One request is taken per cycle unless pix_out back-pressure fills the pipeline. The
// depth is set by the corner distance square root, which resolves two root bits
// per stage over nine stages.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// A stage holds its request while the stage after it is full and cannot load, so empty
// stages still fill while a result waits on pix_out.
// ----------------------------------------------------------------------------
module rounded_rect_coverage_blend_core import rrcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rrcb_pix_in_if.sink    pix_in,
  rrcb_pix_out_if.source pix_out
);

  logic signed [12:0] rect_left;
  logic signed [12:0] rect_top;
  logic [12:0]        rect_width;
  logic [12:0]        rect_height;
  logic [15:0]        corner_radius;
  logic [31:0]        fill_color;
  logic [12:0]        buffer_width;
  logic [12:0]        buffer_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      fill_color    <= '0;
      buffer_width  <= BUF_RST;
      buffer_height <= BUF_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index))
        REG_RECT_LEFT:     rect_left     <= signed'(cfg_data[12:0]);
        REG_RECT_TOP:      rect_top      <= signed'(cfg_data[12:0]);
        REG_RECT_WIDTH:    rect_width    <= cfg_data[12:0];
        REG_RECT_HEIGHT:   rect_height   <= cfg_data[12:0];
        REG_CORNER_RADIUS: corner_radius <= cfg_data[15:0];
        REG_FILL_COLOR:    fill_color    <= cfg_data;
        REG_BUFFER_WIDTH:  buffer_width  <= cfg_data[12:0];
        REG_BUFFER_HEIGHT: buffer_height <= cfg_data[12:0];
      endcase
    end
  end

  logic signed [GEO_W-1:0] ix1, iy1, ix2, iy2, ri;
  logic [12:0]             shorter;
  logic [MAXR_W-1:0]       maxr;
  logic [RAD_W-1:0]        r;
  logic signed [DX_W-1:0]  rs;

  always_comb begin
    ix1     = GEO_W'(rect_left);
    iy1     = GEO_W'(rect_top);
    ix2     = ix1 + signed'(GEO_W'(rect_width));
    iy2     = iy1 + signed'(GEO_W'(rect_height));
    shorter = (rect_width < rect_height) ? rect_width : rect_height;
    maxr    = MAXR_W'(shorter) << (RFRAC - 1);
    r       = (RCMP_W'(corner_radius) < RCMP_W'(maxr)) ? corner_radius : RAD_W'(maxr);
    ri      = signed'(GEO_W'(r >> RFRAC)) + G_ONE;
    rs      = signed'(DX_W'(r));
  end

  // Stage valid bits and load enables.
  logic [NUM_ST-1:0] v;
  logic [NUM_ST-1:0] vin;
  logic [NUM_ST:0]   ld;

  always_comb begin
    ld[NUM_ST] = pix_out.ready;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
    vin = {v[NUM_ST-2:0], pix_in.valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (ld[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  assign pix_in.ready = ld[ST_GEO];

  // Clipping and corner zone tests.
  logic signed [GEO_W-1:0] xs_in, ys_in;
  logic                    skip_in;
  zone_t                   zone_in;

  always_comb begin
    xs_in   = signed'(GEO_W'(pix_in.pixel_x));
    ys_in   = signed'(GEO_W'(pix_in.pixel_y));
    skip_in = (rect_width == '0) || (rect_height == '0)
           || (GEO_W'(pix_in.pixel_x) >= GEO_W'(buffer_width))
           || (GEO_W'(pix_in.pixel_y) >= GEO_W'(buffer_height))
           || (xs_in < ix1 - G_ONE) || (xs_in >= ix2 + G_ONE)
           || (ys_in < iy1 - G_ONE) || (ys_in >= iy2 + G_ONE);
    zone_in.lx = xs_in < ix1 + ri;
    zone_in.rx = xs_in >= ix2 - ri;
    zone_in.ty = ys_in < iy1 + ri;
    zone_in.by = ys_in >= iy2 - ri;
  end

  logic [COORD_BITS-1:0] s0_x, s0_y;
  zone_t                 s0_zone;
  carry_t                s0_c;

  always_ff @(posedge clk) begin
    if (ld[ST_GEO]) begin
      s0_x    <= pix_in.pixel_x;
      s0_y    <= pix_in.pixel_y;
      s0_zone <= zone_in;
      s0_c    <= '{skip: skip_in, dpos: 1'b0, dst: pix_in.dest_pixel};
    end
  end

  // Offsets from the pixel center to the corner center.
  logic signed [GEO_W-1:0] xs1, ys1, gx_l, gx_r, gy_t, gy_b;
  logic signed [DX_W-1:0]  dx_l, dx_r, dy_t, dy_b, dx_sel, dy_sel;
  logic                    dpos1;

  always_comb begin
    xs1  = signed'(GEO_W'(s0_x));
    ys1  = signed'(GEO_W'(s0_y));
    gx_l = ix1 - xs1;
    gx_r = xs1 - ix2;
    gy_t = iy1 - ys1;
    gy_b = ys1 - iy2;
    dx_l = (DX_W'(gx_l) <<< RFRAC) + rs - HALF_D;
    dx_r = (DX_W'(gx_r) <<< RFRAC) + HALF_D + rs;
    dy_t = (DX_W'(gy_t) <<< RFRAC) + rs - HALF_D;
    dy_b = (DX_W'(gy_b) <<< RFRAC) + HALF_D + rs;
    priority if (s0_zone.lx && s0_zone.ty) begin
      dx_sel = dx_l;
      dy_sel = dy_t;
    end else if (s0_zone.rx && s0_zone.ty) begin
      dx_sel = dx_r;
      dy_sel = dy_t;
    end else if (s0_zone.lx && s0_zone.by) begin
      dx_sel = dx_l;
      dy_sel = dy_b;
    end else if (s0_zone.rx && s0_zone.by) begin
      dx_sel = dx_r;
      dy_sel = dy_b;
    end else begin
      dx_sel = DX_ZERO;
      dy_sel = DX_ZERO;
    end
    dpos1 = (dx_sel > DX_ZERO) && (dy_sel > DX_ZERO);
  end

  logic [DP_W-1:0] s1_dx, s1_dy;
  carry_t          s1_c;

  always_ff @(posedge clk) begin
    if (ld[ST_DXY]) begin
      s1_dx <= dx_sel[DP_W-1:0];
      s1_dy <= dy_sel[DP_W-1:0];
      s1_c  <= '{skip: s0_c.skip, dpos: dpos1, dst: s0_c.dst};
    end
  end

  logic [2*DP_W-1:0] s2_sqx, s2_sqy;
  carry_t            s2_c;

  always_ff @(posedge clk) begin
    if (ld[ST_SQR]) begin
      s2_sqx <= (2*DP_W)'(s1_dx) * (2*DP_W)'(s1_dx);
      s2_sqy <= (2*DP_W)'(s1_dy) * (2*DP_W)'(s1_dy);
      s2_c   <= s1_c;
    end
  end

  // Square root pipeline: entry 0 holds the radicand, entry g+1 the state after stage g.
  sq_t    sqs [SQ_STG+1];
  sq_t    sqn [SQ_STG];
  carry_t cs  [SQ_STG+1];

  always_comb begin
    sq_t t;
    for (int g = 0; g < SQ_STG; g++) begin
      t = sqs[g];
      for (int i = 0; i < SQ_ITER; i++) begin
        t = sqrt_step(t);
      end
      sqn[g] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_SUM]) begin
      sqs[0] <= '{rem: '0, root: '0,
                  rad: (2*SQ_BITS)'(s2_sqx) + (2*SQ_BITS)'(s2_sqy)};
      cs[0]  <= s2_c;
    end
    for (int g = 0; g < SQ_STG; g++) begin
      if (ld[ST_RT0+g]) begin
        sqs[g+1] <= sqn[g];
        cs[g+1]  <= cs[g];
      end
    end
  end

  // Coverage from the corner distance and the covered alpha.
  logic [SQ_BITS-1:0] cdist;
  carry_t             cov_c;
  logic [RAD_W:0]     rh, band;
  logic               far, inband, skip_cov;
  logic [COV_W-1:0]   cov;
  logic [16:0]        aprod;
  logic [7:0]         pa;

  always_comb begin
    cdist  = sqs[SQ_STG].root;
    cov_c  = cs[SQ_STG];
    rh     = (RAD_W + 1)'(r) + HALF;
    far    = SQ_BITS'(rh) < cdist;
    inband = ((SQ_BITS + 1)'(cdist) + (SQ_BITS + 1)'(HALF)) > (SQ_BITS + 1)'(r);
    band   = rh - (RAD_W + 1)'(cdist);
    if (cov_c.dpos && inband) begin
      cov = COV_W'(band[RFRAC-1:0]) << (8 - RFRAC);
    end else begin
      cov = COV_FULL;
    end
    aprod    = 17'(fill_color[31:24]) * 17'(cov);
    pa       = aprod[15:8];
    skip_cov = cov_c.skip || (cov_c.dpos && far) || (pa == 8'd0);
  end

  logic [7:0] s13_pa;
  carry_t     s13_c;

  always_ff @(posedge clk) begin
    if (ld[ST_COV]) begin
      s13_pa <= pa;
      s13_c  <= '{skip: skip_cov, dpos: cov_c.dpos, dst: cov_c.dst};
    end
  end

  logic [7:0]  inv;
  logic [15:0] m_da, m_fr, m_dr, m_fg, m_dg, m_fb, m_db;
  logic [7:0]  s14_pa;
  carry_t      s14_c;

  assign inv = 8'd255 - s13_pa;

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      m_da   <= 16'(s13_c.dst[31:24]) * 16'(inv);
      m_fr   <= 16'(fill_color[23:16]) * 16'(s13_pa);
      m_dr   <= 16'(s13_c.dst[23:16]) * 16'(inv);
      m_fg   <= 16'(fill_color[15:8]) * 16'(s13_pa);
      m_dg   <= 16'(s13_c.dst[15:8]) * 16'(inv);
      m_fb   <= 16'(fill_color[7:0]) * 16'(s13_pa);
      m_db   <= 16'(s13_c.dst[7:0]) * 16'(inv);
      s14_pa <= s13_pa;
      s14_c  <= s13_c;
    end
  end

  logic [31:0] blend;
  logic        o_we;
  logic [31:0] o_pix;

  always_comb begin
    blend[31:24] = s14_pa + div255(m_da);
    blend[23:16] = div255(m_fr) + div255(m_dr);
    blend[15:8]  = div255(m_fg) + div255(m_dg);
    blend[7:0]   = div255(m_fb) + div255(m_db);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      o_we  <= !s14_c.skip;
      o_pix <= s14_c.skip ? s14_c.dst : blend;
    end
  end

  assign pix_out.valid        = v[ST_OUT];
  assign pix_out.write_enable = o_we;
  assign pix_out.new_pixel    = o_pix;

  for (genvar k = 0; k < NUM_ST; k++) begin : g_hold_chk
    a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      v[k] && !ld[k+1] |=> v[k])
      else $error("pipeline stage lost a request while stalled");
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("result valid right after reset");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    v[ST_COV-1] |-> sqs[SQ_STG].rem <= {sqs[SQ_STG].root, 1'b0})
    else $error("square root remainder out of range");

  a_written_alpha: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.write_enable |-> pix_out.new_pixel[31:24] != 8'd0)
    else $error("written pixel has zero alpha");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rounded rectangle coverage blend core. Pixel
// requests go in through a queue-fed driver. A monitor computes the expected
// blended pixel for each accepted request and compares its write enable and
// whole pixel with the returned result, under changing rectangle, color and
// buffer settings, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb import rrcb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [31:0]           dst;
  } pix_req_t;

  typedef struct packed {
    logic        we;
    logic [31:0] pix;
  } blend_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  cfg_idx_e    cfg_index;
  logic [31:0] cfg_data;

  rrcb_pix_in_if  pin();
  rrcb_pix_out_if pout();

  rounded_rect_coverage_blend_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pin),
    .pix_out   (pout)
  );

  logic signed [12:0] geo_left;
  logic signed [12:0] geo_top;
  logic [12:0]        geo_w;
  logic [12:0]        geo_h;
  logic [15:0]        geo_rad;
  logic [31:0]        fill;
  logic [12:0]        buf_w;
  logic [12:0]        buf_h;

  pix_req_t    pend_q[$];
  blend_t      blend_q[$];
  int          n_issued;
  int          n_seen;
  int          n_errors;
  int unsigned cycle_cnt;
  int          in_idle;
  int          out_idle;
  logic        hold_off;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint isqrt_floor(longint s);
    longint root;
    longint t;
    root = 0;
    for (int b = 30; b >= 0; b--) begin
      t = root | (longint'(1) << b);
      if (t * t <= s) root = t;
    end
    return root;
  endfunction

  function automatic blend_t predict_blend(pix_req_t rq);
    longint x, y, ix1, iy1, ix2, iy2, shorter, r, ri;
    longint dx, dy, cdist, cov, a, pa, inv, one_q, half_q;
    blend_t res;
    one_q  = longint'(1) << RFRAC;
    half_q = longint'(1) << (RFRAC - 1);
    res.we  = 1'b0;
    res.pix = rq.dst;
    x   = longint'(rq.x);
    y   = longint'(rq.y);
    ix1 = longint'(geo_left);
    iy1 = longint'(geo_top);
    ix2 = ix1 + longint'(geo_w);
    iy2 = iy1 + longint'(geo_h);
    dx  = 0;
    dy  = 0;
    cov = 256;
    if (geo_w == 0 || geo_h == 0) return res;
    if (x >= longint'(buf_w) || y >= longint'(buf_h)) return res;
    if (x < ix1 - 1 || x >= ix2 + 1 || y < iy1 - 1 || y >= iy2 + 1) return res;
    shorter = (geo_w < geo_h) ? longint'(geo_w) : longint'(geo_h);
    r  = (longint'(geo_rad) < (shorter << (RFRAC - 1))) ? longint'(geo_rad)
                                                        : (shorter << (RFRAC - 1));
    ri = (r >> RFRAC) + 1;
    if (x < ix1 + ri && y < iy1 + ri) begin
      dx = (ix1 - x) * one_q + r - half_q;
      dy = (iy1 - y) * one_q + r - half_q;
    end else if (x >= ix2 - ri && y < iy1 + ri) begin
      dx = (x - ix2) * one_q + half_q + r;
      dy = (iy1 - y) * one_q + r - half_q;
    end else if (x < ix1 + ri && y >= iy2 - ri) begin
      dx = (ix1 - x) * one_q + r - half_q;
      dy = (y - iy2) * one_q + half_q + r;
    end else if (x >= ix2 - ri && y >= iy2 - ri) begin
      dx = (x - ix2) * one_q + half_q + r;
      dy = (y - iy2) * one_q + half_q + r;
    end
    if (dx > 0 && dy > 0) begin
      cdist = isqrt_floor(dx * dx + dy * dy);
      if (cdist > r + half_q) return res;
      if (cdist > r - half_q) cov = ((r + half_q - cdist) << 8) >> RFRAC;
    end
    a  = longint'(fill[31:24]);
    pa = (a * cov) >> 8;
    if (pa == 0) return res;
    inv = 255 - pa;
    res.we = 1'b1;
    res.pix[31:24] = 8'(pa + longint'(rq.dst[31:24]) * inv / 255);
    res.pix[23:16] = 8'(longint'(fill[23:16]) * pa / 255 + longint'(rq.dst[23:16]) * inv / 255);
    res.pix[15:8]  = 8'(longint'(fill[15:8]) * pa / 255 + longint'(rq.dst[15:8]) * inv / 255);
    res.pix[7:0]   = 8'(longint'(fill[7:0]) * pa / 255 + longint'(rq.dst[7:0]) * inv / 255);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch %0d: %s got %h want %h (result %0d)", n_errors, what, got, want,
               n_seen);
  endtask

  task automatic wr_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RECT_LEFT:     geo_left = val[12:0];
      REG_RECT_TOP:      geo_top  = val[12:0];
      REG_RECT_WIDTH:    geo_w    = val[12:0];
      REG_RECT_HEIGHT:   geo_h    = val[12:0];
      REG_CORNER_RADIUS: geo_rad  = val[15:0];
      REG_FILL_COLOR:    fill     = val;
      REG_BUFFER_WIDTH:  buf_w    = val[12:0];
      REG_BUFFER_HEIGHT: buf_h    = val[12:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_rect(int left, int top, int w, int h, int rad, logic [31:0] color,
                          int bw, int bh);
    wr_reg(REG_RECT_LEFT, 32'(left));
    wr_reg(REG_RECT_TOP, 32'(top));
    wr_reg(REG_RECT_WIDTH, 32'(w));
    wr_reg(REG_RECT_HEIGHT, 32'(h));
    wr_reg(REG_CORNER_RADIUS, 32'(rad));
    wr_reg(REG_FILL_COLOR, color);
    wr_reg(REG_BUFFER_WIDTH, 32'(bw));
    wr_reg(REG_BUFFER_HEIGHT, 32'(bh));
  endtask

  task automatic send(int x, int y, logic [31:0] dst);
    pix_req_t rq;
    rq.x   = COORD_BITS'(x);
    rq.y   = COORD_BITS'(y);
    rq.dst = dst;
    pend_q.push_back(rq);
    n_issued++;
  endtask

  task automatic drain(int extra);
    while (n_seen < n_issued) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Mostly lands near a corner band or inside the widened box, otherwise anywhere.
  function automatic int pick_coord(int lo, int len, int ri);
    int c;
    case ($urandom_range(6))
      0, 1:    c = lo - 1 + int'($urandom_range(ri + 1));
      2, 3:    c = lo + len - int'($urandom_range(ri + 1));
      4, 5:    c = lo - 1 + int'($urandom_range(len + 1));
      default: c = int'($urandom_range(4095));
    endcase
    if (c < 0 || c > 4095) c = int'($urandom_range(4095));
    return c;
  endfunction

  task automatic run_random_phase(int count);
    int left, top, w, h, rad, shorter, r, ri, bw, bh;
    logic [31:0] color;
    w = ($urandom_range(9) == 0) ? int'($urandom_range(4096)) : int'($urandom_range(1, 48));
    h = ($urandom_range(9) == 0) ? int'($urandom_range(4096)) : int'($urandom_range(1, 48));
    if ($urandom_range(24) == 0) w = 0;
    left = ($urandom_range(7) == 0) ? int'($urandom_range(8191)) - 4096
                                    : int'($urandom_range(4100)) - 8;
    top  = ($urandom_range(7) == 0) ? int'($urandom_range(8191)) - 4096
                                    : int'($urandom_range(4100)) - 8;
    shorter = (w < h) ? w : h;
    case ($urandom_range(3))
      0:       rad = int'($urandom_range(65535));
      1:       rad = int'($urandom_range(shorter * 8 + 40));
      2:       rad = shorter * 8;
      default: rad = int'($urandom_range(20)) * 16 + int'($urandom_range(15));
    endcase
    if (rad > 65535) rad = 65535;
    color = $urandom;
    case ($urandom_range(5))
      0:       color[31:24] = 8'hFF;
      1:       color[31:24] = 8'($urandom_range(1, 8));
      default: ;
    endcase
    bw = 4096;
    bh = 4096;
    if ($urandom_range(3) == 0) bw = left + int'($urandom_range(w + 1));
    if ($urandom_range(3) == 0) bh = top + int'($urandom_range(h + 1));
    if (bw < 1 || bw > 4096) bw = int'($urandom_range(1, 4096));
    if (bh < 1 || bh > 4096) bh = int'($urandom_range(1, 4096));
    set_rect(left, top, w, h, rad, color, bw, bh);
    r  = (rad < shorter * 8) ? rad : shorter * 8;
    ri = (r >> RFRAC) + 1;
    for (int i = 0; i < count; i++)
      send(pick_coord(left, w, ri), pick_coord(top, h, ri), $urandom);
  endtask

  always @(posedge clk) begin
    pix_req_t rq;
    if (rst) begin
      pin.valid <= 1'b0;
    end else if (!pin.valid || pin.ready) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= in_idle) begin
        rq = pend_q.pop_front();
        pin.valid      <= 1'b1;
        pin.pixel_x    <= rq.x;
        pin.pixel_y    <= rq.y;
        pin.dest_pixel <= rq.dst;
      end else begin
        pin.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_off && hold_cnt < HOLD_CYCLES) begin
      pout.ready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      pout.ready <= ($urandom_range(99) >= out_idle);
      if (!hold_off) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    pix_req_t rq;
    blend_t   want;
    if (!rst) begin
      if (pin.valid && pin.ready) begin
        rq.x   = pin.pixel_x;
        rq.y   = pin.pixel_y;
        rq.dst = pin.dest_pixel;
        blend_q.push_back(predict_blend(rq));
      end
      if (pout.valid && pout.ready) begin
        n_seen++;
        if (blend_q.size() == 0) begin
          report_mismatch("result with no pending request", pout.new_pixel, 32'h0);
        end else begin
          want = blend_q.pop_front();
          if (pout.write_enable !== want.we)
            report_mismatch("write_enable", 32'(pout.write_enable), 32'(want.we));
          if (pout.new_pixel !== want.pix)
            report_mismatch("new_pixel", pout.new_pixel, want.pix);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cycle_cnt, n_seen,
               n_issued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_RECT_LEFT;
    cfg_data       = 32'h0;
    pin.valid      = 1'b0;
    pin.pixel_x    = '0;
    pin.pixel_y    = '0;
    pin.dest_pixel = 32'h0;
    pout.ready     = 1'b0;
    geo_left       = '0;
    geo_top        = '0;
    geo_w          = '0;
    geo_h          = '0;
    geo_rad        = '0;
    fill           = 32'h0;
    buf_w          = 13'd4096;
    buf_h          = 13'd4096;
    n_issued       = 0;
    n_seen         = 0;
    n_errors       = 0;
    cycle_cnt      = 0;
    in_idle        = 30;
    out_idle       = 79;
    hold_off       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // After reset the rectangle is empty.
    send(100, 100, 32'h12345678);
    drain(2);

    // Corners, straight margins, interior and outside of a small rectangle.
    set_rect(10, 20, 40, 30, 128, 32'hFF804020, 4096, 4096);
    send(9, 19, 32'hFFFFFFFF);
    send(10, 20, 32'h00000000);
    send(11, 21, 32'hFFFFFFFF);
    send(12, 22, 32'h00000000);
    send(30, 35, 32'hFFFFFFFF);
    send(9, 35, 32'h00000000);
    send(8, 35, 32'hFFFFFFFF);
    send(50, 50, 32'h00000000);
    send(49, 49, 32'hA5A5A5A5);
    send(40, 49, 32'h5A5A5A5A);
    drain(2);

    // Zero fill alpha, then a partial corner whose scaled alpha rounds to zero.
    wr_reg(REG_FILL_COLOR, 32'h00FFFFFF);
    send(30, 35, 32'h11223344);
    drain(2);
    wr_reg(REG_FILL_COLOR, 32'h01FFFFFF);
    send(12, 22, 32'h11223344);
    drain(2);

    // Empty buffer, then a buffer edge that cuts through the rectangle.
    wr_reg(REG_FILL_COLOR, 32'hFF804020);
    wr_reg(REG_BUFFER_WIDTH, 32'd0);
    send(30, 35, 32'h55667788);
    drain(2);
    wr_reg(REG_BUFFER_WIDTH, 32'd20);
    send(19, 35, 32'h55667788);
    send(20, 35, 32'h55667788);
    drain(2);

    set_rect(-4096, -4096, 4096, 4096, 65535, 32'hFFFFFFFF, 4096, 4096);
    send(0, 0, 32'h00000000);
    send(4095, 4095, 32'hFFFFFFFF);
    drain(2);
    set_rect(4095, 4095, 1, 1, 0, 32'h80FF00FF, 4096, 4096);
    send(4095, 4095, 32'h00000000);
    send(4094, 4094, 32'hFFFFFFFF);
    drain(2);
    set_rect(0, 0, 4096, 4096, 64, 32'hC0336699, 4096, 4096);
    send(4095, 0, 32'h80808080);
    send(2048, 2048, 32'h7F7F7F7F);
    drain(2);

    for (int p = 0; p < 13; p++) begin
      if (p < 5) begin
        in_idle  = 30;
        out_idle = 79;
      end else if (p < 10) begin
        in_idle  = 79;
        out_idle = 30;
      end else begin
        in_idle  = 0;
        out_idle = 0;
      end
      hold_off = (p == 10);
      run_random_phase(100);
      drain(2);
      hold_off = 1'b0;
    end

    drain(DRAIN_CYCLES);
    if (blend_q.size() != 0)
      report_mismatch("expected results left over", 32'(blend_q.size()), 32'h0);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
